/* rtl/lir_pkg.sv */
`default_nettype none

package lir_pkg;

    // field and counter widths
    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 16;
    localparam int RATE_BITS   = 18;
    localparam int COUNT_BITS  = 32;
    localparam int CHAN_BITS   = 2;
    localparam int INDEX_BITS  = 2;
    localparam int TDATA_BITS  = 2 * SAMPLE_BITS;

    // results per request and the counter that tracks them
    localparam int MAX_OUT  = 48;
    localparam int NUM_BITS = $clog2(MAX_OUT + 1);
    localparam logic [NUM_BITS-1:0] MAX_OUT_N = NUM_BITS'(MAX_OUT);

    // position arithmetic: count times rate, plus one rate step
    localparam int PROD_BITS = COUNT_BITS + RATE_BITS;
    localparam int CMP_BITS  = PROD_BITS + 1;

    // long division of (index * model_rate) << FRAC_BITS by target_rate
    localparam int DIVIDEND_BITS  = PROD_BITS + FRAC_BITS;
    localparam int DIV_RADIX_BITS = 2;
    localparam int DIV_STEPS      = DIVIDEND_BITS / DIV_RADIX_BITS;
    localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS);

    // interpolation datapath
    localparam int DIFF_BITS  = SAMPLE_BITS + 1;
    localparam int BPROD_BITS = DIFF_BITS + FRAC_BITS + 1;

    // small queues on either side of the sequencer
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int FILL_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [RATE_BITS-1:0] DEFAULT_RATE  = RATE_BITS'(48000);
    localparam logic [CHAN_BITS-1:0] CHAN_MONO     = CHAN_BITS'(1);
    localparam logic [CHAN_BITS-1:0] CHAN_RESET    = CHAN_BITS'(2);

    typedef enum logic [INDEX_BITS-1:0] {
        REG_MODEL_RATE    = 2'd0,
        REG_TARGET_RATE   = 2'd1,
        REG_CHANNEL_COUNT = 2'd2
    } cfg_reg_t;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        sample_t left;
        sample_t right;
        logic    fin;
    } frame_t;

    typedef struct packed {
        sample_t left;
        sample_t right;
        logic    last;
    } result_t;

    typedef struct packed {
        logic [RATE_BITS-1:0] model;
        logic [RATE_BITS-1:0] target;
        logic                 mono;
    } rate_cfg_t;

    typedef struct packed {
        logic                     start;
        logic [DIVIDEND_BITS-1:0] dividend;
        logic [RATE_BITS-1:0]     divisor;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic [DIVIDEND_BITS-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

/* rtl/lir_front.sv */
`default_nettype none

module lir_front
    import lir_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_BITS-1:0] s_tdata,
    input  logic                  s_tlast,
    input  logic                  mono,
    input  logic                  pop,
    output frame_t                head,
    output logic                  head_valid
);

    frame_t                mem_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FILL_BITS-1:0]  fill_reg, fill_next;
    frame_t                entry;
    logic                  wr_en;
    logic                  rd_en;

    // mono requests carry a zero right sample from here on
    always_comb begin
        entry.left  = s_tdata[SAMPLE_BITS-1:0];
        entry.right = mono ? '0 : s_tdata[TDATA_BITS-1:SAMPLE_BITS];
        entry.fin   = s_tlast;
    end

    assign s_tready   = (fill_reg != FILL_BITS'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign wr_en      = s_tvalid && s_tready;
    assign rd_en      = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en) begin
            fill_next = fill_reg + 1'b1;
        end else if (rd_en && !wr_en) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

`default_nettype wire

/* rtl/lir_div.sv */
`default_nettype none

module lir_div
    import lir_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIVIDEND_BITS-1:0] num_reg, num_next;
    logic [RATE_BITS-1:0]     rem_reg, rem_next;
    logic [RATE_BITS-1:0]     dvs_reg;
    logic [DIV_CNT_BITS-1:0]  cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;

    // restoring division, two quotient bits a cycle; quotient shifts in behind the dividend
    always_comb begin
        logic [RATE_BITS:0] trial;
        logic               qbit;
        rem_next = rem_reg;
        num_next = num_reg;
        for (int j = 0; j < DIV_RADIX_BITS; j++) begin
            trial = {rem_next, num_next[DIVIDEND_BITS-1]};
            qbit  = 1'b0;
            if (trial >= {1'b0, dvs_reg}) begin
                trial = trial - {1'b0, dvs_reg};
                qbit  = 1'b1;
            end
            rem_next = trial[RATE_BITS-1:0];
            num_next = {num_next[DIVIDEND_BITS-2:0], qbit};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = num_reg;

endmodule

`default_nettype wire

/* rtl/lir_core.sv */
`default_nettype none

module lir_core
    import lir_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  rate_cfg_t cfg,
    input  frame_t    head,
    input  logic      head_valid,
    output logic      pop,
    output div_req_t  div_req,
    input  div_rsp_t  div_rsp,
    output logic      push,
    output result_t   push_data,
    input  logic      out_space
);

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b0000_0000_0001,
        ST_MUL      = 12'b0000_0000_0010,
        ST_SUM      = 12'b0000_0000_0100,
        ST_HOLD     = 12'b0000_0000_1000,
        ST_LOOP     = 12'b0000_0001_0000,
        ST_DIV      = 12'b0000_0010_0000,
        ST_BMUL     = 12'b0000_0100_0000,
        ST_BSUM     = 12'b0000_1000_0000,
        ST_LHOLD    = 12'b0001_0000_0000,
        ST_RES      = 12'b0010_0000_0000,
        ST_FALLBACK = 12'b0100_0000_0000,
        ST_FLUSH    = 12'b1000_0000_0000
    } state_t;

    localparam logic [BPROD_BITS:0] ROUND_HALF =
        {{(BPROD_BITS + 1 - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

    state_t                  state_reg, state_next;
    frame_t                  cur_reg, cur_next;
    sample_t                 prev_l_reg, prev_l_next;
    sample_t                 prev_r_reg, prev_r_next;
    logic [COUNT_BITS-1:0]   frames_reg, frames_next;
    logic [COUNT_BITS-1:0]   oi_reg, oi_next;
    logic                    have_prev_reg, have_prev_next;
    logic                    hold_valid_reg, hold_valid_next;
    sample_t                 hold_l_reg, hold_l_next;
    sample_t                 hold_r_reg, hold_r_next;
    logic [PROD_BITS-1:0]    a_reg, a_next;
    logic [PROD_BITS-1:0]    b_reg, b_next;
    logic [CMP_BITS-1:0]     am_reg, am_next;
    logic [CMP_BITS-1:0]     bt_reg, bt_next;
    logic                    looping_reg, looping_next;
    logic [NUM_BITS-1:0]     n_reg, n_next;
    logic                    pend_valid_reg, pend_valid_next;
    sample_t                 pend_l_reg, pend_l_next;
    sample_t                 pend_r_reg, pend_r_next;
    logic signed [BPROD_BITS-1:0] pl_reg, pl_next;
    logic signed [BPROD_BITS-1:0] pr_reg, pr_next;
    sample_t                 res_l_reg, res_l_next;
    sample_t                 res_r_reg, res_r_next;

    logic                    put_en;
    logic                    put_ok;
    sample_t                 put_l;
    sample_t                 put_r;
    logic signed [DIFF_BITS-1:0]  diff_l;
    logic signed [DIFF_BITS-1:0]  diff_r;
    logic signed [FRAC_BITS:0]    frac_s;
    logic signed [BPROD_BITS:0]   vl;
    logic signed [BPROD_BITS:0]   vr;
    logic signed [BPROD_BITS:0]   ql;
    logic signed [BPROD_BITS:0]   qr;
    logic [SAMPLE_BITS-1:0]  blend_l;
    logic [SAMPLE_BITS-1:0]  blend_r;
    logic [PROD_BITS-1:0]    i0;
    logic                    use_blend;
    logic [CMP_BITS-1:0]     held_pos;

    // a result may be placed once the pending slot can drain or the cap swallows it
    assign put_ok = (n_reg >= MAX_OUT_N) || !pend_valid_reg || out_space;

    // blend datapath
    always_comb begin
        diff_l  = {cur_reg.left[SAMPLE_BITS-1], cur_reg.left} - {prev_l_reg[SAMPLE_BITS-1], prev_l_reg};
        diff_r  = {cur_reg.right[SAMPLE_BITS-1], cur_reg.right} - {prev_r_reg[SAMPLE_BITS-1], prev_r_reg};
        frac_s  = {1'b0, div_rsp.quotient[FRAC_BITS-1:0]};
        vl      = {pl_reg[BPROD_BITS-1], pl_reg} + ROUND_HALF;
        vr      = {pr_reg[BPROD_BITS-1], pr_reg} + ROUND_HALF;
        ql      = vl >>> FRAC_BITS;
        qr      = vr >>> FRAC_BITS;
        blend_l = prev_l_reg + ql[SAMPLE_BITS-1:0];
        blend_r = prev_r_reg + qr[SAMPLE_BITS-1:0];
        i0      = div_rsp.quotient[DIVIDEND_BITS-1:FRAC_BITS];
        use_blend = !cur_reg.fin || (have_prev_reg && (i0 < PROD_BITS'(frames_reg)));
        // position of the held output; a wrapped index means 2^32 steps
        held_pos = (oi_reg == '0) ? {1'b0, cfg.model, {COUNT_BITS{1'b0}}} : {1'b0, a_reg};
    end

    always_comb begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        prev_l_next     = prev_l_reg;
        prev_r_next     = prev_r_reg;
        frames_next     = frames_reg;
        oi_next         = oi_reg;
        have_prev_next  = have_prev_reg;
        hold_valid_next = hold_valid_reg;
        hold_l_next     = hold_l_reg;
        hold_r_next     = hold_r_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        am_next         = am_reg;
        bt_next         = bt_reg;
        looping_next    = looping_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_l_next     = pend_l_reg;
        pend_r_next     = pend_r_reg;
        pl_next         = pl_reg;
        pr_next         = pr_reg;
        res_l_next      = res_l_reg;
        res_r_next      = res_r_reg;
        pop             = 1'b0;
        push            = 1'b0;
        push_data.left  = pend_l_reg;
        push_data.right = pend_r_reg;
        push_data.last  = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = {a_reg, {FRAC_BITS{1'b0}}};
        div_req.divisor  = cfg.target;
        put_en          = 1'b0;
        put_l           = res_l_reg;
        put_r           = res_r_reg;

        case (state_reg)
            ST_IDLE: begin
                if (head_valid) begin
                    pop          = 1'b1;
                    cur_next     = head;
                    n_next       = '0;
                    looping_next = 1'b0;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL: begin
                a_next = {{RATE_BITS{1'b0}}, oi_reg} * {{COUNT_BITS{1'b0}}, cfg.model};
                b_next = {{RATE_BITS{1'b0}}, frames_reg} * {{COUNT_BITS{1'b0}}, cfg.target};
                state_next = ST_SUM;
            end
            ST_SUM: begin
                am_next    = {1'b0, a_reg} + CMP_BITS'(cfg.model);
                bt_next    = {1'b0, b_reg} + CMP_BITS'(cfg.target);
                state_next = looping_reg ? ST_LOOP : ST_HOLD;
            end
            ST_HOLD: begin
                put_l = hold_l_reg;
                put_r = hold_r_reg;
                if (!cur_reg.fin) begin
                    if (hold_valid_reg && ({1'b0, a_reg} <= bt_reg)) begin
                        if (put_ok) begin
                            put_en          = 1'b1;
                            hold_valid_next = 1'b0;
                            state_next      = ST_LOOP;
                        end
                    end else begin
                        state_next = ST_LOOP;
                    end
                end else begin
                    // final request: the held output stays flagged for the fallback test
                    if (hold_valid_reg && ((held_pos <= bt_reg) ||
                                           (oi_reg == COUNT_BITS'(1)))) begin
                        if (put_ok) begin
                            put_en     = 1'b1;
                            state_next = ST_LOOP;
                        end
                    end else begin
                        state_next = ST_LOOP;
                    end
                end
            end
            ST_LOOP: begin
                looping_next = 1'b1;
                if (!cur_reg.fin) begin
                    if (have_prev_reg && (n_reg < MAX_OUT_N) && (a_reg < b_reg)) begin
                        div_req.start = 1'b1;
                        state_next    = ST_DIV;
                    end else begin
                        state_next = ST_FLUSH;
                    end
                end else begin
                    if ((n_reg < MAX_OUT_N) && (am_reg <= bt_reg)) begin
                        div_req.start = 1'b1;
                        state_next    = ST_DIV;
                    end else begin
                        state_next = ST_FALLBACK;
                    end
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = ST_BMUL;
                end
            end
            ST_BMUL: begin
                pl_next    = diff_l * frac_s;
                pr_next    = diff_r * frac_s;
                state_next = ST_BSUM;
            end
            ST_BSUM: begin
                res_l_next = use_blend ? blend_l : cur_reg.left;
                res_r_next = use_blend ? blend_r : cur_reg.right;
                state_next = cur_reg.fin ? ST_RES : ST_LHOLD;
            end
            ST_LHOLD: begin
                put_l = hold_l_reg;
                put_r = hold_r_reg;
                if (!hold_valid_reg) begin
                    state_next = ST_RES;
                end else if (put_ok) begin
                    put_en          = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_RES;
                end
            end
            ST_RES: begin
                if (!cur_reg.fin && (am_reg > bt_reg)) begin
                    // too early to release: park it until the stream proves long enough
                    hold_valid_next = 1'b1;
                    hold_l_next     = res_l_reg;
                    hold_r_next     = res_r_reg;
                    oi_next         = oi_reg + 1'b1;
                    state_next      = ST_MUL;
                end else if (put_ok) begin
                    put_en     = 1'b1;
                    oi_next    = oi_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_FALLBACK: begin
                put_l = cur_reg.left;
                put_r = cur_reg.right;
                if ((n_reg == '0) && (oi_reg == '0) && !hold_valid_reg) begin
                    if (put_ok) begin
                        put_en     = 1'b1;
                        state_next = ST_FLUSH;
                    end
                end else begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg || out_space) begin
                    push           = pend_valid_reg;
                    push_data.last = cur_reg.fin;
                    pend_valid_next = 1'b0;
                    if (cur_reg.fin) begin
                        prev_l_next     = '0;
                        prev_r_next     = '0;
                        frames_next     = '0;
                        oi_next         = '0;
                        have_prev_next  = 1'b0;
                        hold_valid_next = 1'b0;
                    end else begin
                        prev_l_next    = cur_reg.left;
                        prev_r_next    = cur_reg.right;
                        have_prev_next = 1'b1;
                        frames_next    = frames_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // one result slot is kept back so the last of a request can be flagged
        if (put_en && (n_reg < MAX_OUT_N)) begin
            push            = pend_valid_reg;
            pend_valid_next = 1'b1;
            pend_l_next     = put_l;
            pend_r_next     = cfg.mono ? '0 : put_r;
            n_next          = n_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            frames_reg     <= '0;
            oi_reg         <= '0;
            have_prev_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
            looping_reg    <= 1'b0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            frames_reg     <= frames_next;
            oi_reg         <= oi_next;
            have_prev_reg  <= have_prev_next;
            hold_valid_reg <= hold_valid_next;
            looping_reg    <= looping_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        prev_l_reg <= prev_l_next;
        prev_r_reg <= prev_r_next;
        hold_l_reg <= hold_l_next;
        hold_r_reg <= hold_r_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        am_reg     <= am_next;
        bt_reg     <= bt_next;
        pend_l_reg <= pend_l_next;
        pend_r_reg <= pend_r_next;
        pl_reg     <= pl_next;
        pr_reg     <= pr_next;
        res_l_reg  <= res_l_next;
        res_r_reg  <= res_r_next;
    end

endmodule

`default_nettype wire

/* rtl/lir_out.sv */
`default_nettype none

module lir_out
    import lir_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  result_t               push_data,
    output logic                  space,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_BITS-1:0] m_tdata,
    output logic                  m_tlast
);

    result_t               mem_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FILL_BITS-1:0]  fill_reg, fill_next;
    result_t               head;
    logic                  rd_en;

    assign space    = (fill_reg != FILL_BITS'(QUEUE_DEPTH));
    assign m_tvalid = (fill_reg != '0);
    assign head     = mem_reg[rd_ptr_reg];
    assign m_tdata  = {head.right, head.left};
    assign m_tlast  = head.last;
    assign rd_en    = m_tvalid && m_tready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !rd_en) begin
            fill_next = fill_reg + 1'b1;
        end else if (rd_en && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/linear_interp_resampler_top.sv */
`default_nettype none

// Streaming linear-interpolation resampler. Audio frames at model_rate come in one request
// at a time (left and right Q1.23 samples, tlast on the final frame of a stream) and leave
// at target_rate: output i sits at i*model_rate/target_rate, blended between the frames
// on either side with a 16-bit fraction rounded to nearest, the last frame repeated past the
// end. A stream of N frames gives floor(N*target_rate/model_rate) outputs, at least one,
// the final one flagged with tlast, and at most 48 per input request. A rate of zero counts
// as 48000; channel_count 1 gives mono (right ignored on entry, zero on exit). The user must
// write registers through the cfg port only while no request is in flight; the block itself
// does not enforce this. Each output position it works out goes through the shared 66-bit
// divider, which resolves two quotient bits a cycle. Two-entry queues on both sides let the
// input side keep taking requests while results wait to be taken.
module linear_interp_resampler_top
    import lir_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input frames
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_BITS-1:0] s_tdata,   // sample_left [23:0], sample_right [47:24]
    input  logic                  s_tlast,   // final_frame
    // resampled output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_BITS-1:0] m_tdata,   // out_left [23:0], out_right [47:24]
    output logic                  m_tlast,   // last_output
    // register writes
    input  logic                  cfg_wr_en,
    input  logic [INDEX_BITS-1:0] cfg_index,
    input  logic [RATE_BITS-1:0]  cfg_data
);

    logic [RATE_BITS-1:0] model_rate_reg;
    logic [RATE_BITS-1:0] target_rate_reg;
    logic [CHAN_BITS-1:0] chan_count_reg;
    rate_cfg_t            cfg;

    frame_t               head;
    logic                 head_valid;
    logic                 pop;
    div_req_t             div_req;
    div_rsp_t             div_rsp;
    logic                 push;
    result_t              push_data;
    logic                 out_space;

    // register file, write only
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            model_rate_reg  <= DEFAULT_RATE;
            target_rate_reg <= DEFAULT_RATE;
            chan_count_reg  <= CHAN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MODEL_RATE:    model_rate_reg  <= cfg_data;
                REG_TARGET_RATE:   target_rate_reg <= cfg_data;
                REG_CHANNEL_COUNT: chan_count_reg  <= cfg_data[CHAN_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // effective rates: zero falls back to the default rate; anything but one channel is stereo
    always_comb begin
        cfg.model  = (model_rate_reg == '0) ? DEFAULT_RATE : model_rate_reg;
        cfg.target = (target_rate_reg == '0) ? DEFAULT_RATE : target_rate_reg;
        cfg.mono   = (chan_count_reg == CHAN_MONO);
    end

    // intake and queue of frames
    lir_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .mono       (cfg.mono),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    // phase and fraction divider shared by every output position
    lir_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // sequencer: stream state, release and hold decisions, blending
    lir_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .div_req    (div_req),
        .div_rsp    (div_rsp),
        .push       (push),
        .push_data  (push_data),
        .out_space  (out_space)
    );

    // result queue towards the output channel
    lir_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .space     (out_space),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

/* rtl/lir_checker.sv */
`default_nettype none

module lir_checker
    import lir_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [TDATA_BITS-1:0] m_tdata,
    input logic                  m_tlast
);

    logic seen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            seen_reg <= 1'b1;
        end
    end

    // both queues come out of reset empty
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (s_tready && !m_tvalid))
        else $error("queues not empty after reset");

    // no result before any frame has been taken
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> seen_reg)
        else $error("result without any input frame");

    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("output valid dropped while stalled");

    a_data_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tlast)))
        else $error("output payload changed while stalled");

endmodule

bind linear_interp_resampler_top lir_checker u_lir_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

/* sim/tb_top.sv */
`default_nettype none

module tb_top;
    import lir_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef longint unsigned u64_t;

    localparam sample_t SAMPLE_MAX  = sample_t'(24'h7FFFFF);
    localparam sample_t SAMPLE_MIN  = sample_t'(24'h800000);
    localparam int      SETTLE_WAIT = 400;   // worst bookkeeping left after the last result
    localparam int      LONG_HOLD   = 400;   // receiver hold-off for the pressure test
    localparam int      RANDOM_FRAMES = 200;
    localparam int      MAX_REPORTS = 40;

    // clock, reset and all block inputs at known values from time zero
    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [TDATA_BITS-1:0] s_tdata = '0;    // sample_left [23:0], sample_right [47:24]
    logic                  s_tlast = 1'b0;  // final_frame
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_BITS-1:0] m_tdata;         // out_left [23:0], out_right [47:24]
    logic                  m_tlast;         // last_output
    logic                  cfg_wr_en = 1'b0;
    logic [INDEX_BITS-1:0] cfg_index = REG_MODEL_RATE;
    logic [RATE_BITS-1:0]  cfg_data = '0;

    linear_interp_resampler_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 50 MHz clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    // hard stop, far beyond the slowest legal run
    initial begin
        #100_000_000;
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // resampler predictor: register copy and stream state
    // ------------------------------------------------------------------
    logic [RATE_BITS-1:0] cfg_model  = DEFAULT_RATE;
    logic [RATE_BITS-1:0] cfg_target = DEFAULT_RATE;
    logic [CHAN_BITS-1:0] cfg_chans  = CHAN_RESET;

    longint    last_l = 0;         // previous frame of the stream
    longint    last_r = 0;
    bit [31:0] frame_count = '0;   // frames taken in this stream
    bit [31:0] next_out = '0;      // next output index to work out
    bit        primed = 1'b0;      // previous frame is valid
    bit        held_valid = 1'b0;  // output worked out but not yet due
    longint    held_l = 0;
    longint    held_r = 0;

    // outputs still owed by the block, oldest first
    result_t   pending_outputs[$];
    result_t   staged;             // newest output of the current request, last flag open
    int        batch_count;

    int        mismatches = 0;
    int        frames_sent = 0;
    int        sink_hold = 0;      // one-off receiver hold-off, picked up by the sink
    bit        source_steady = 1'b0;
    bit        sink_steady = 1'b0;

    int unsigned common_rates [12] = '{8000, 11025, 16000, 22050, 24000, 32000,
                                       44100, 48000, 88200, 96000, 176400, 192000};

    function automatic u64_t eff_rate(input logic [RATE_BITS-1:0] r);
        // a zero rate falls back to the default
        return (r == '0) ? u64_t'(DEFAULT_RATE) : u64_t'(r);
    endfunction

    // s0 + round((s1 - s0) * frac / 2^FRAC_BITS), ties toward plus infinity
    function automatic longint mix(input longint a, input longint b, input u64_t frac);
        longint v;
        v = (b - a) * longint'(frac) + (longint'(1) <<< (FRAC_BITS - 1));
        return a + (v >>> FRAC_BITS);
    endfunction

    function automatic void interp_at(input bit [31:0] idx, input longint cl,
                                      input longint cr, output longint l, output longint r);
        u64_t m;
        u64_t t;
        u64_t rem;
        u64_t frac;
        m    = eff_rate(cfg_model);
        t    = eff_rate(cfg_target);
        rem  = (u64_t'(idx) * m) % t;
        frac = (rem << FRAC_BITS) / t;
        l    = mix(last_l, cl, frac);
        r    = mix(last_r, cr, frac);
    endfunction

    // anything past the per-request bound is dropped
    function automatic void emit(input longint l, input longint r);
        result_t o;
        if (batch_count >= MAX_OUT)
            return;
        o.left  = l[SAMPLE_BITS-1:0];
        o.right = (cfg_chans == CHAN_MONO) ? '0 : r[SAMPLE_BITS-1:0];
        o.last  = 1'b0;
        if (batch_count > 0)
            pending_outputs.push_back(staged);
        staged = o;
        batch_count++;
    endfunction

    // outputs caused by one accepted frame request
    function automatic void resample_frame(input sample_t il, input sample_t ir, input bit fin);
        u64_t      m;
        u64_t      t;
        u64_t      k;
        u64_t      cnt;
        u64_t      i0;
        u64_t      idx;
        longint    cl;
        longint    cr;
        longint    l;
        longint    r;
        bit [31:0] i;
        m   = eff_rate(cfg_model);
        t   = eff_rate(cfg_target);
        cl  = il;
        cr  = ir;
        if (cfg_chans == CHAN_MONO)
            cr = 0;
        k   = frame_count;
        cnt = k + 1;
        batch_count = 0;

        if (!fin) begin
            // a held output is released as soon as the stream is long enough
            if (held_valid && u64_t'(next_out) * m <= cnt * t) begin
                emit(held_l, held_r);
                held_valid = 1'b0;
            end
            if (primed) begin
                while (batch_count < MAX_OUT && u64_t'(next_out) * m < k * t) begin
                    i = next_out;
                    interp_at(i, cl, cr, l, r);
                    if (held_valid) begin
                        emit(held_l, held_r);
                        held_valid = 1'b0;
                    end
                    if ((u64_t'(i) + 1) * m <= cnt * t) begin
                        emit(l, r);
                    end else begin
                        held_valid = 1'b1;
                        held_l     = l;
                        held_r     = r;
                    end
                    next_out = i + 32'd1;
                end
            end
            last_l      = cl;
            last_r      = cr;
            primed      = 1'b1;
            frame_count = cnt[31:0];
        end else begin
            // held output survives the end only if due, or if it is output zero
            if (held_valid) begin
                idx = u64_t'(next_out - 32'd1);
                if ((idx + 1) * m <= cnt * t || idx == 0)
                    emit(held_l, held_r);
            end
            // remaining outputs, the final frame repeated past the end
            while (batch_count < MAX_OUT && (u64_t'(next_out) + 1) * m <= cnt * t) begin
                i  = next_out;
                i0 = u64_t'(i) * m / t;
                if (primed && i0 < k) begin
                    interp_at(i, cl, cr, l, r);
                end else begin
                    l = cl;
                    r = cr;
                end
                emit(l, r);
                next_out = i + 32'd1;
            end
            // a stream always gives at least one output
            if (batch_count == 0 && next_out == '0 && !held_valid)
                emit(cl, cr);
            last_l      = 0;
            last_r      = 0;
            frame_count = '0;
            next_out    = '0;
            primed      = 1'b0;
            held_valid  = 1'b0;
            held_l      = 0;
            held_r      = 0;
        end

        if (batch_count > 0) begin
            staged.last = fin;
            pending_outputs.push_back(staged);
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic sample_t rand_sample();
        sample_t s;
        case ($urandom_range(0, 5))
            0:       s = SAMPLE_MIN;
            1:       s = SAMPLE_MAX;
            2:       s = sample_t'($signed($urandom_range(0, 31)) - 16);   // near zero
            default: s = sample_t'($urandom());
        endcase
        return s;
    endfunction

    function automatic logic [RATE_BITS-1:0] pick_rate();
        logic [RATE_BITS-1:0] r;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: r = RATE_BITS'(common_rates[$urandom_range(0, 11)]);
            6, 7, 8:          r = RATE_BITS'($urandom_range(8000, 192000));
            default:          r = ($urandom_range(0, 1) == 1) ? '1 : '0;
        endcase
        return r;
    endfunction

    // one frame request: optional gap, then hold valid until taken
    task automatic send_frame(input sample_t l, input sample_t r, input bit fin);
        int gap;
        gap = source_steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r, l};
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        resample_frame(l, r, fin);
        frames_sent++;
    endtask

    task automatic send_stream(input int len);
        for (int j = 1; j <= len; j++)
            send_frame(rand_sample(), rand_sample(), j == len);
    endtask

    // stop offering, wait for every owed output, then let the block go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
    endtask

    // writes all three registers on consecutive edges; block must be idle
    task automatic set_rates(input logic [RATE_BITS-1:0] model,
                             input logic [RATE_BITS-1:0] target,
                             input logic [CHAN_BITS-1:0] chans);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_MODEL_RATE;
        cfg_data  <= model;
        @(posedge aclk);
        cfg_index <= REG_TARGET_RATE;
        cfg_data  <= target;
        @(posedge aclk);
        cfg_index <= REG_CHANNEL_COUNT;
        cfg_data  <= RATE_BITS'(chans);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_model  = model;
        cfg_target = target;
        cfg_chans  = chans;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset rates are equal, so samples pass straight through; field extremes
    task automatic test_passthrough();
        send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        send_frame(sample_t'(0), sample_t'(-1), 1'b0);
        send_frame(sample_t'(-1), sample_t'(0), 1'b1);
    endtask

    // short streams give at least one output, also those too short for any natural output
    task automatic test_short_streams();
        send_frame(sample_t'(24'h123456), sample_t'(24'hABCDEF), 1'b1);
        settle();
        set_rates(RATE_BITS'(48000), RATE_BITS'(8000), CHAN_RESET);
        send_frame(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
        send_frame(SAMPLE_MIN, SAMPLE_MIN, 1'b1);
        settle();
        set_rates('1, RATE_BITS'(8000), CHAN_MONO);
        send_frame(sample_t'(24'h55AA55), sample_t'(24'hAA55AA), 1'b1);
    endtask

    // zero rate means the default; mono zeroes right, a channel count of three means stereo
    task automatic test_zero_rate_and_mono();
        settle();
        set_rates('0, RATE_BITS'(44100), CHAN_MONO);
        send_stream(5);
        settle();
        set_rates(RATE_BITS'(22050), '0, CHAN_BITS'(3));
        send_stream(3);
    endtask

    // huge upsampling ratio hits the per-request bound on both frame kinds
    task automatic test_result_cap();
        settle();
        set_rates(RATE_BITS'(1), '1, '0);
        send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
    endtask

    // target rate changed halfway through a stream
    task automatic test_midstream_rate_change();
        settle();
        set_rates(RATE_BITS'(44100), RATE_BITS'(48000), CHAN_RESET);
        send_frame(rand_sample(), rand_sample(), 1'b0);
        send_frame(rand_sample(), rand_sample(), 1'b0);
        send_frame(rand_sample(), rand_sample(), 1'b0);
        settle();
        set_rates(RATE_BITS'(44100), RATE_BITS'(96000), CHAN_RESET);
        send_stream(3);
    endtask

    // receiver stalls long enough to back up the input; sender pauses mid-stream
    task automatic test_backpressure();
        settle();
        set_rates(RATE_BITS'(32000), RATE_BITS'(48000), CHAN_RESET);
        source_steady = 1'b1;
        sink_hold     = LONG_HOLD;
        send_stream(14);
        source_steady = 1'b0;
        send_frame(rand_sample(), rand_sample(), 1'b0);
        send_frame(rand_sample(), rand_sample(), 1'b0);
        // pause until every owed output is out, then carry on the same stream
        settle();
        send_stream(4);
    endtask

    // random configurations, several streams each, random flow control
    task automatic test_random_streams();
        int start;
        start = frames_sent;
        while (frames_sent - start < RANDOM_FRAMES) begin
            settle();
            source_steady = ($urandom_range(0, 3) == 0);
            sink_steady   = ($urandom_range(0, 3) == 0);
            set_rates(pick_rate(), pick_rate(), CHAN_BITS'($urandom_range(0, 3)));
            repeat ($urandom_range(1, 4))
                send_stream($urandom_range(1, 16));
        end
        source_steady = 1'b0;
        sink_steady   = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result side: random ready, one-off long hold-off
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (sink_hold > 0) begin
                stall     = sink_hold;
                sink_hold = 0;
            end else if (sink_steady) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 4);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // every output request against the oldest owed output
    always @(posedge aclk) begin : output_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_outputs.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: unexpected output left=%h right=%h last=%b", $time,
                             m_tdata[SAMPLE_BITS-1:0], m_tdata[TDATA_BITS-1:SAMPLE_BITS],
                             m_tlast);
                mismatches++;
            end else begin
                want = pending_outputs.pop_front();
                if (m_tdata[SAMPLE_BITS-1:0] !== want.left ||
                    m_tdata[TDATA_BITS-1:SAMPLE_BITS] !== want.right ||
                    m_tlast !== want.last) begin
                    if (mismatches < MAX_REPORTS)
                        $display("%0t: output mismatch expected l=%h r=%h last=%b got l=%h r=%h last=%b",
                                 $time, want.left, want.right, want.last,
                                 m_tdata[SAMPLE_BITS-1:0], m_tdata[TDATA_BITS-1:SAMPLE_BITS],
                                 m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_passthrough();
        test_short_streams();
        test_zero_rate_and_mono();
        test_result_cap();
        test_midstream_rate_change();
        test_backpressure();
        test_random_streams();
        settle();

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

/* linear_interp_resampler_top.f */
rtl/lir_pkg.sv
rtl/lir_front.sv
rtl/lir_div.sv
rtl/lir_core.sv
rtl/lir_out.sv
rtl/linear_interp_resampler_top.sv
rtl/lir_checker.sv
sim/tb_top.sv
